@@ src/fas_pkg.sv @@
// Shared types and constants for the FIFO with alternate-entry spread.
package fas_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int FUNC_W        = 2;
    localparam int STATUS_W      = 2;

    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SPREAD = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [DATA_W-1:0] SIGN_BIAS = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_WAIT,
        ST_SPR_SCAN,
        ST_SPR_DONE
    } state_t;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_POP,
        SEL_SPREAD
    } out_sel_t;

    typedef struct packed {
        logic                push_wr;
        logic                head_rd;
        logic                scan_start;
        logic                scan_step;
        logic                pop_commit;
        logic                out_load;
        out_sel_t            out_sel;
        logic [STATUS_W-1:0] out_status;
    } cmd_t;

    typedef struct packed {
        logic occ_zero;
        logic occ_full;
        logic scan_last;
    } stat_t;

endpackage

@@ src/fas_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/fas_ctrl.sv @@
// Controller state machine: handshakes, operation decode and sequencing.
module fas_ctrl
    import fas_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [FUNC_W-1:0] s_func,
    output logic              m_valid,
    input  logic              m_ready,
    input  stat_t             stat,
    output cmd_t              cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_func == FUNC_POP && !stat.occ_zero) begin
                        state_next = ST_POP_WAIT;
                    end else if (s_func == FUNC_SPREAD && !stat.occ_zero) begin
                        state_next = ST_SPR_SCAN;
                    end
                end
            end
            ST_POP_WAIT: state_next = ST_IDLE;
            ST_SPR_SCAN: begin
                if (stat.scan_last) begin
                    state_next = ST_SPR_DONE;
                end
            end
            ST_SPR_DONE: state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd            = '0;
        cmd.out_sel    = SEL_ZERO;
        cmd.out_status = STATUS_OK;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_func)
                        FUNC_PUSH: begin
                            cmd.out_load = 1'b1;
                            if (stat.occ_full) begin
                                cmd.out_status = STATUS_FULL;
                            end else begin
                                cmd.push_wr = 1'b1;
                            end
                        end
                        FUNC_POP: begin
                            if (stat.occ_zero) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = STATUS_EMPTY;
                            end else begin
                                cmd.head_rd = 1'b1;
                            end
                        end
                        FUNC_SPREAD: begin
                            if (stat.occ_zero) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = STATUS_EMPTY;
                            end else begin
                                cmd.head_rd    = 1'b1;
                                cmd.scan_start = 1'b1;
                            end
                        end
                        default: begin
                            cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP_WAIT: begin
                cmd.pop_commit = 1'b1;
                cmd.out_load   = 1'b1;
                cmd.out_sel    = SEL_POP;
            end
            ST_SPR_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            ST_SPR_DONE: begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = SEL_SPREAD;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ src/fas_dp.sv @@
// Datapath: storage, pointers, occupancy, spread scan and result register.
module fas_dp
    import fas_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic signed [DATA_W-1:0]   s_push_value,
    input  cmd_t                       cmd,
    output stat_t                      stat,
    output logic        [STATUS_W-1:0] m_status,
    output logic signed [DATA_W-1:0]   m_popped_value,
    output logic        [DATA_W-1:0]   m_spread_value
);

    localparam int PW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);
    localparam logic [PW:0] DEPTH_P = (PW + 1)'(DEPTH);

    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [OW-1:0]     occ_reg, occ_next;
    logic [PW-1:0]     scan_idx_reg, scan_idx_next;
    logic [OW-1:0]     left_reg, left_next;
    logic [DATA_W-1:0] hi_reg, hi_next;
    logic [DATA_W-1:0] lo_reg, lo_next;
    logic [STATUS_W-1:0] status_reg;
    logic [DATA_W-1:0] popped_reg;
    logic [DATA_W-1:0] spread_reg;

    logic [PW:0]       rd_inc, wr_inc, base_add2, scan_add2;
    logic [PW-1:0]     scan_base;
    logic [OW:0]       half_sum;
    logic [DATA_W-1:0] rdata, biased;
    logic [PW-1:0]     raddr;
    logic              re;

    assign raddr = cmd.head_rd ? rd_ptr_reg : scan_idx_reg;
    assign re    = cmd.head_rd || (cmd.scan_step && !stat.scan_last);

    fas_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (cmd.push_wr),
        .waddr(wr_ptr_reg),
        .wdata(s_push_value),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign stat.occ_zero  = (occ_reg == '0);
    assign stat.occ_full  = (occ_reg == OW'(DEPTH));
    assign stat.scan_last = (left_reg == OW'(1));

    assign biased    = rdata ^ SIGN_BIAS;
    assign scan_base = cmd.scan_start ? rd_ptr_reg : scan_idx_reg;
    assign half_sum  = {1'b0, occ_reg} + (OW + 1)'(1);

    always_comb begin
        rd_inc    = {1'b0, rd_ptr_reg} + (PW + 1)'(1);
        wr_inc    = {1'b0, wr_ptr_reg} + (PW + 1)'(1);
        base_add2 = {1'b0, scan_base} + (PW + 1)'(2);
        scan_add2 = (base_add2 >= DEPTH_P) ? (base_add2 - DEPTH_P) : base_add2;
        if (rd_inc >= DEPTH_P) begin
            rd_inc = '0;
        end
        if (wr_inc >= DEPTH_P) begin
            wr_inc = '0;
        end
    end

    always_comb begin
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        occ_next      = occ_reg;
        scan_idx_next = scan_idx_reg;
        left_next     = left_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        if (cmd.push_wr) begin
            wr_ptr_next = wr_inc[PW-1:0];
            occ_next    = occ_reg + OW'(1);
        end
        if (cmd.pop_commit) begin
            rd_ptr_next = rd_inc[PW-1:0];
            occ_next    = occ_reg - OW'(1);
        end
        if (cmd.scan_start) begin
            scan_idx_next = scan_add2[PW-1:0];
            left_next     = half_sum[OW:1];
            hi_next       = '0;
            lo_next       = '1;
        end
        if (cmd.scan_step) begin
            scan_idx_next = scan_add2[PW-1:0];
            left_next     = left_reg - OW'(1);
            if (biased > hi_reg) begin
                hi_next = biased;
            end
            if (biased < lo_reg) begin
                lo_next = biased;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            occ_reg    <= '0;
            left_reg   <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            occ_reg    <= occ_next;
            left_reg   <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        if (cmd.out_load) begin
            status_reg <= cmd.out_status;
            popped_reg <= (cmd.out_sel == SEL_POP) ? rdata : '0;
            spread_reg <= (cmd.out_sel == SEL_SPREAD) ? (hi_reg - lo_reg) : '0;
        end
    end

    assign m_status       = status_reg;
    assign m_popped_value = popped_reg;
    assign m_spread_value = spread_reg;

endmodule

@@ src/fifo_with_alternate_spread.sv @@
// Top level of the FIFO that reports the spread over every second entry.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_func, s_push_value
//  m_      | out       | m_valid / m_ready  | m_status, m_popped_value, m_spread_value
//
// A push, an operation on an empty queue and the unused code are answered at acceptance, with a registered result.
// A pop passes through ST_POP_WAIT because the storage read data is registered.
// A spread walks every second entry from the head, ceil(occupancy/2) entries in all,
// through the single storage read port, in the states ST_SPR_SCAN and ST_SPR_DONE.
// Reset clears the pointers, occupancy and result valid; the storage keeps no reset.
// A stalled result holds in its register, and the next word is taken once it is free.
module fifo_with_alternate_spread
    import fas_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic        [FUNC_W-1:0]   s_func,
    input  logic signed [DATA_W-1:0]   s_push_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic        [STATUS_W-1:0] m_status,
    output logic signed [DATA_W-1:0]   m_popped_value,
    output logic        [DATA_W-1:0]   m_spread_value
);

    cmd_t  cmd;
    stat_t stat;

    fas_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func (s_func),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    fas_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_push_value  (s_push_value),
        .cmd           (cmd),
        .stat          (stat),
        .m_status      (m_status),
        .m_popped_value(m_popped_value),
        .m_spread_value(m_spread_value)
    );

endmodule
